FILE: sv/stip_pkg.sv
// Shared types and constants of the string-to-integer parser.
`default_nettype none
package stip_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 7;
    localparam int POS_W    = 16;
    localparam int OFFSET_W = 16;
    localparam int PROD_W   = VALUE_W + BASE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] MAX_LENGTH = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 2'd2;

    localparam logic [BASE_W-1:0]  RESET_BASE      = 6'd10;
    localparam logic [VALUE_W-1:0] RESET_MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BAD   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

    localparam logic [DIGIT_W-1:0] NO_DIGIT  = 7'd99;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic last_item;
        logic out_free;
    } ctl_status_t;

endpackage
`default_nettype wire

FILE: sv/stip_ctrl.sv
// Controller state machine: sequences capture, digit step and result load.
`default_nettype none
module stip_ctrl
    import stip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire ctl_status_t status,
    output ctl_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.capture = s_tvalid && s_tready;
        cmd.step    = (state_reg == ST_STEP);
        cmd.finish  = (state_reg == ST_FINISH) && status.out_free;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = status.last_item ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/stip_datapath.sv
// Datapath: configuration registers, parse state, multiply-accumulate and result register.
`default_nettype none
module stip_datapath
    import stip_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctl_cmd_t              cmd,
    output ctl_status_t                status,
    input  wire logic [CHAR_W-1:0]     s_char,
    input  wire logic                  s_last,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VALUE_W-1:0]    cfg_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [VALUE_W-1:0]         m_value,
    output logic [OFFSET_W-1:0]        m_offset,
    output logic                       m_converted,
    output logic                       m_range_error
);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_XSEEN  = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            t = c - CH_ZERO;
            return t[DIGIT_W-1:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            t = c - CH_LOWER_A + 8'd10;
            return t[DIGIT_W-1:0];
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            t = c - CH_UPPER_A + 8'd10;
            return t[DIGIT_W-1:0];
        end
        return NO_DIGIT;
    endfunction

    logic [BASE_W-1:0]  number_base_reg;
    logic               signed_mode_reg;
    logic [VALUE_W-1:0] max_value_reg;

    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [2:0]         phase_reg,     phase_next;
    logic [VALUE_W-1:0] magnitude_reg, magnitude_next;
    logic               negative_reg,  negative_next;
    logic [BASE_W-1:0]  abase_reg,     abase_next;
    logic [POS_W-1:0]   char_pos_reg,  char_pos_next;
    logic [POS_W-1:0]   end_pos_reg,   end_pos_next;
    logic               seen_reg,      seen_next;
    logic               ovf_reg,       ovf_next;
    logic [PROD_W-1:0]  prod_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg,  out_value_next;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic               out_conv_reg;
    logic               out_rerr_reg;

    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] limit;
    logic [PROD_W-1:0]  sum;
    logic [POS_W-1:0]   mark_pos;
    logic               is_space;
    logic               start;
    logic               take;
    logic [BASE_W-1:0]  take_base;
    logic [BASE_W-1:0]  auto_base;
    logic               neg_out;

    assign digit    = digit_of(char_reg);
    assign sum      = prod_reg + {{(PROD_W-DIGIT_W){1'b0}}, digit};
    assign mark_pos = (char_pos_reg == MAX_LENGTH) ? MAX_LENGTH : char_pos_reg + 1'b1;
    assign is_space = (char_reg == CH_SPACE) || (char_reg >= CH_TAB && char_reg <= CH_CR);
    assign neg_out  = negative_reg && signed_mode_reg;

    always_comb
    begin
        if (signed_mode_reg && negative_reg && (max_value_reg != {VALUE_W{1'b1}}))
        begin
            limit = max_value_reg + 1'b1;
        end
        else
        begin
            limit = max_value_reg;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        magnitude_next = magnitude_reg;
        negative_next  = negative_reg;
        abase_next     = abase_reg;
        end_pos_next   = end_pos_reg;
        seen_next      = seen_reg;
        ovf_next       = ovf_reg;
        char_pos_next  = (char_pos_reg == MAX_LENGTH) ? char_pos_reg : char_pos_reg + 1'b1;
        start          = 1'b0;
        take           = 1'b0;
        take_base      = abase_reg;
        auto_base      = (number_base_reg == BASE_AUTO) ? BASE_DEC : number_base_reg;

        case (phase_reg)
            PH_SPACE:
            begin
                if (!is_space)
                begin
                    if (char_reg == CH_MINUS && signed_mode_reg)
                    begin
                        negative_next = 1'b1;
                        phase_next    = PH_START;
                    end
                    else if (char_reg == CH_PLUS)
                    begin
                        phase_next = PH_START;
                    end
                    else
                    begin
                        start = 1'b1;
                    end
                end
            end
            PH_START:
            begin
                start = 1'b1;
            end
            PH_ZERO:
            begin
                if (char_reg == CH_LOWER_X || char_reg == CH_UPPER_X)
                begin
                    phase_next = PH_XSEEN;
                end
                else if (digit < {1'b0, abase_reg})
                begin
                    take       = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_XSEEN:
            begin
                if (digit < {1'b0, BASE_HEX})
                begin
                    abase_next = BASE_HEX;
                    take_base  = BASE_HEX;
                    take       = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (digit < {1'b0, abase_reg})
                begin
                    take = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (start)
        begin
            if (number_base_reg == BASE_BAD || number_base_reg > BASE_MAX)
            begin
                phase_next = PH_DONE;
            end
            else if (char_reg == CH_ZERO)
            begin
                seen_next    = 1'b1;
                end_pos_next = mark_pos;
                if (number_base_reg == BASE_AUTO || number_base_reg == BASE_HEX)
                begin
                    abase_next = (number_base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    abase_next = number_base_reg;
                    phase_next = PH_DIGITS;
                end
            end
            else if (digit < {1'b0, auto_base})
            begin
                abase_next = auto_base;
                take_base  = auto_base;
                take       = 1'b1;
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (take)
        begin
            seen_next    = 1'b1;
            end_pos_next = mark_pos;
            if (!ovf_reg && take_base >= 6'd2)
            begin
                if (sum > {{(PROD_W-VALUE_W){1'b0}}, limit})
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    magnitude_next = sum[VALUE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (!seen_reg)
        begin
            out_value_next = '0;
        end
        else if (ovf_reg)
        begin
            out_value_next = neg_out ? ({VALUE_W{1'b0}} - limit) : max_value_reg;
        end
        else
        begin
            out_value_next = neg_out ? ({VALUE_W{1'b0}} - magnitude_reg) : magnitude_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= RESET_BASE;
            signed_mode_reg <= 1'b1;
            max_value_reg   <= RESET_MAX_VALUE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUMBER_BASE: number_base_reg <= cfg_data[BASE_W-1:0];
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {{(PROD_W-VALUE_W){1'b0}}, magnitude_reg}
                  * {{(PROD_W-BASE_W){1'b0}}, abase_reg};
        if (cmd.capture)
        begin
            char_reg <= s_char;
            last_reg <= s_last;
        end
        if (cmd.finish)
        begin
            out_value_reg  <= out_value_next;
            out_offset_reg <= seen_reg ? end_pos_reg[OFFSET_W-1:0] : '0;
            out_conv_reg   <= seen_reg;
            out_rerr_reg   <= seen_reg && ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            magnitude_reg <= '0;
            negative_reg  <= 1'b0;
            abase_reg     <= '0;
            char_pos_reg  <= '0;
            end_pos_reg   <= '0;
            seen_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                phase_reg     <= PH_SPACE;
                magnitude_reg <= '0;
                negative_reg  <= 1'b0;
                abase_reg     <= '0;
                char_pos_reg  <= '0;
                end_pos_reg   <= '0;
                seen_reg      <= 1'b0;
                ovf_reg       <= 1'b0;
            end
            else if (cmd.step)
            begin
                phase_reg     <= phase_next;
                magnitude_reg <= magnitude_next;
                negative_reg  <= negative_next;
                abase_reg     <= abase_next;
                char_pos_reg  <= char_pos_next;
                end_pos_reg   <= end_pos_next;
                seen_reg      <= seen_next;
                ovf_reg       <= ovf_next;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.last_item = last_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign m_value       = out_value_reg;
    assign m_offset      = out_offset_reg;
    assign m_converted   = out_conv_reg;
    assign m_range_error = out_rerr_reg;

endmodule
`default_nettype wire

FILE: sv/string_to_integer_parser_top.sv
// Top level of the string-to-integer parser: controller plus datapath.
//
// Input channel s_*: one character per beat, s_tlast marks the final character.
// Output channel m_*: one result beat per string, issued after the tlast beat.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no string is in progress.
// Each character passes through an accept state and a step state; the step
// adds the digit to the product of the magnitude and base, registered in
// the cycle before, and compares against the limit. After the final
// character a finish state forms the result in the output register once
// that register is free.
// A finished result waits in the output register while the next string's
// characters are accepted; a final character stalls only until the output
// register is taken.
// Reset clears the parse state and the output valid and loads the register
// defaults: base 10, signed mode, maximum 2^63-1.
`default_nettype none
module string_to_integer_parser_top
    import stip_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // char_code[7:0]
    input  wire logic                  s_tlast,   // is_last
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [79:0]                m_tdata,   // result_value[63:0], end_offset[79:64]
    output logic [1:0]                 m_tuser,   // converted[0], range_error[1]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VALUE_W-1:0]    cfg_data
);

    ctl_cmd_t            cmd;
    ctl_status_t         status;
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    logic                converted;
    logic                range_error;

    assign cfg_ready = 1'b1;

    stip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    stip_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_char        (s_tdata),
        .s_last        (s_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_value       (value),
        .m_offset      (offset),
        .m_converted   (converted),
        .m_range_error (range_error)
    );

    assign m_tdata = {offset, value};
    assign m_tuser = {range_error, converted};

endmodule
`default_nettype wire

FILE: sv/stip_checker.sv
// Port-level checker for the string-to-integer parser, bound to the top level.
`default_nettype none
module stip_checker
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [79:0]           m_tdata,
    input wire logic [1:0]            m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_step_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("character accepted during step cycle");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 80'd0 && !m_tuser[1])
        else $error("unconverted result not zero");

    a_range_conv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[79:64] != 16'd0)
        else $error("range error without conversion");

endmodule

bind string_to_integer_parser_top stip_checker u_stip_checker (.*);
`default_nettype wire

FILE: tb/string_to_integer_parser_top_tb.sv
// Self-checking stream testbench of the string-to-integer parser.
`timescale 1ns / 100ps
module string_to_integer_parser_top_tb;
    import stip_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;

    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;

    typedef enum logic [2:0] {
        SCAN_BLANK,
        SCAN_SIGN_SEEN,
        SCAN_LEAD_ZERO,
        SCAN_PREFIX_X,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_e;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [OFFSET_W-1:0] offset;
        logic                converted;
        logic                range_err;
    } parse_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [79:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]   cfg_data  = '0;

    logic [BASE_W-1:0]  base_reg;
    logic               signed_reg;
    logic [VALUE_W-1:0] max_reg;

    scan_phase_e        scan_phase;
    logic [VALUE_W-1:0] accum;
    logic               negative;
    logic [BASE_W-1:0]  radix;
    logic [POS_W-1:0]   char_count;
    logic [POS_W-1:0]   stop_pos;
    logic               any_digit;
    logic               saturated;

    parse_result_t expected_results[$];
    int unsigned   send_gap_pct;
    int unsigned   recv_gap_pct;
    int unsigned   fail_count  = 0;
    int unsigned   cycle_count = 0;

    string_to_integer_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    function automatic void clear_scan();
        scan_phase = SCAN_BLANK;
        accum      = '0;
        negative   = 1'b0;
        radix      = '0;
        char_count = '0;
        stop_pos   = '0;
        any_digit  = 1'b0;
        saturated  = 1'b0;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return DIGIT_W'(c - CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return DIGIT_W'(c - CH_LOWER_A + 8'd10);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return DIGIT_W'(c - CH_UPPER_A + 8'd10);
        return NO_DIGIT;
    endfunction

    function automatic logic [VALUE_W-1:0] value_limit();
        if (signed_reg && negative)
            return (&max_reg) ? max_reg : max_reg + 64'd1;
        return max_reg;
    endfunction

    function automatic void note_end();
        stop_pos = (char_count == MAX_LENGTH) ? MAX_LENGTH : char_count + 16'd1;
    endfunction

    function automatic void take_digit(input logic [DIGIT_W-1:0] d);
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] quot;
        logic [VALUE_W-1:0] rem;
        lim = value_limit();
        b = {{(VALUE_W-BASE_W){1'b0}}, radix};
        any_digit = 1'b1;
        note_end();
        if (saturated || b < 64'd2)
            return;
        quot = lim / b;
        rem = lim % b;
        if (accum > quot || (accum == quot && d > rem))
            saturated = 1'b1;
        else
            accum = accum * b + d;
    endfunction

    function automatic void begin_number(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0]  eff;
        logic [DIGIT_W-1:0] d;
        if (base_reg == BASE_BAD || base_reg > BASE_MAX)
        begin
            scan_phase = SCAN_DONE;
            return;
        end
        if (c == CH_ZERO)
        begin
            any_digit = 1'b1;
            note_end();
            if (base_reg == BASE_AUTO || base_reg == BASE_HEX)
            begin
                radix = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                scan_phase = SCAN_LEAD_ZERO;
            end
            else
            begin
                radix = base_reg;
                scan_phase = SCAN_DIGITS;
            end
            return;
        end
        eff = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
        d = digit_value(c);
        if (d < eff)
        begin
            radix = eff;
            take_digit(d);
            scan_phase = SCAN_DIGITS;
        end
        else
            scan_phase = SCAN_DONE;
    endfunction

    function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic last,
                                      output parse_result_t res);
        logic [DIGIT_W-1:0] d;
        logic               neg;
        res = '0;
        d = digit_value(c);
        case (scan_phase)
            SCAN_BLANK:
            begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                begin
                    if (c == CH_MINUS && signed_reg)
                    begin
                        negative = 1'b1;
                        scan_phase = SCAN_SIGN_SEEN;
                    end
                    else if (c == CH_PLUS)
                        scan_phase = SCAN_SIGN_SEEN;
                    else
                        begin_number(c);
                end
            end
            SCAN_SIGN_SEEN:
                begin_number(c);
            SCAN_LEAD_ZERO:
            begin
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                    scan_phase = SCAN_PREFIX_X;
                else if (d < radix)
                begin
                    take_digit(d);
                    scan_phase = SCAN_DIGITS;
                end
                else
                    scan_phase = SCAN_DONE;
            end
            SCAN_PREFIX_X:
            begin
                if (d < BASE_HEX)
                begin
                    radix = BASE_HEX;
                    take_digit(d);
                    scan_phase = SCAN_DIGITS;
                end
                else
                    scan_phase = SCAN_DONE;
            end
            SCAN_DIGITS:
            begin
                if (d < radix)
                    take_digit(d);
                else
                    scan_phase = SCAN_DONE;
            end
            default:
                scan_phase = SCAN_DONE;
        endcase
        if (char_count != MAX_LENGTH)
            char_count = char_count + 16'd1;
        if (!last)
            return 1'b0;
        if (any_digit)
        begin
            neg = negative && signed_reg;
            if (saturated)
                res.value = neg ? 64'd0 - value_limit() : max_reg;
            else
                res.value = neg ? 64'd0 - accum : accum;
            res.offset    = stop_pos;
            res.converted = 1'b1;
            res.range_err = saturated;
        end
        clear_scan();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with no expected result: tdata 0x%0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("result_value", want.value, m_tdata[63:0]);
                check_field("end_offset", VALUE_W'(want.offset),
                            VALUE_W'(m_tdata[79:64]));
                check_field("converted", VALUE_W'(want.converted), VALUE_W'(m_tuser[0]));
                check_field("range_error", VALUE_W'(want.range_err), VALUE_W'(m_tuser[1]));
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        parse_result_t res;
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (parse_char(c, last, res))
            expected_results.push_back(res);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_NUMBER_BASE: base_reg = val[BASE_W-1:0];
            CFG_SIGNED_MODE: signed_reg = val[0];
            CFG_MAX_VALUE:   max_reg = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [BASE_W-1:0] base, input logic sign_on,
                             input logic [VALUE_W-1:0] limit);
        wait_for_results();
        write_reg(CFG_NUMBER_BASE, {{(VALUE_W-BASE_W){1'b0}}, base});
        write_reg(CFG_SIGNED_MODE, {{(VALUE_W-1){1'b0}}, sign_on});
        write_reg(CFG_MAX_VALUE, limit);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_ZERO + CHAR_W'(d);
        return (($urandom_range(1) != 0) ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'(d - 10);
    endfunction

    task automatic send_random_string(output int unsigned count);
        logic [CHAR_W-1:0] txt[$];
        logic [CHAR_W-1:0] ch;
        int unsigned       pick;
        int unsigned       radix_gen;
        int unsigned       n_digits;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            repeat ($urandom_range(1, 6)) txt.push_back(CHAR_W'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                pick = $urandom_range(5);
                ch = (pick == 0) ? CH_SPACE : CH_TAB + CHAR_W'(pick - 1);
                txt.push_back(ch);
            end
            pick = $urandom_range(7);
            if (pick == 5)
                txt.push_back(CH_PLUS);
            else if (pick == 6)
                txt.push_back(CH_MINUS);
            else if (pick == 7)
            begin
                txt.push_back(CH_PLUS);
                txt.push_back(CH_MINUS);
            end
            radix_gen = (base_reg == BASE_BAD || base_reg > BASE_MAX) ? 32'(BASE_DEC)
                                                                      : 32'(base_reg);
            pick = $urandom_range(2);
            if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && pick == 0)
            begin
                txt.push_back(CH_ZERO);
                txt.push_back(($urandom_range(1) != 0) ? CH_LOWER_X : CH_UPPER_X);
                radix_gen = 32'(BASE_HEX);
            end
            else if (base_reg == BASE_AUTO && pick == 1)
            begin
                txt.push_back(CH_ZERO);
                radix_gen = 32'(BASE_OCT);
            end
            else if (base_reg == BASE_AUTO)
            begin
                txt.push_back(digit_char($urandom_range(1, 9)));
                radix_gen = 32'(BASE_DEC);
            end
            n_digits = ($urandom_range(3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            repeat (n_digits) txt.push_back(digit_char($urandom_range(radix_gen - 1)));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) txt.push_back(CHAR_W'($urandom_range(255)));
            if (txt.size() == 0)
                txt.push_back(digit_char(0));
        end
        foreach (txt[i])
            send_char(txt[i], i == txt.size() - 1);
        count = txt.size();
    endtask

    task automatic test_reset_defaults();
        send_text(" -42");
        send_char(CH_TAB, 1'b0);
        send_char(CH_LF, 1'b0);
        send_char(CH_VT, 1'b0);
        send_char(CH_FF, 1'b0);
        send_char(CH_CR, 1'b0);
        send_text("+7z");
        send_char(8'hFF, 1'b1);
        send_char(CH_MINUS, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_auto_base();
        configure(BASE_AUTO, 1'b1, 64'd100);
        send_text("0x1F");
        send_text("0Xg");
        send_text("017");
        send_text("-101");
        send_text("102");
    endtask

    task automatic test_base_extremes();
        configure(BASE_BAD, 1'b1, RESET_MAX_VALUE);
        send_text("5");
        configure({BASE_W{1'b1}}, 1'b1, RESET_MAX_VALUE);
        send_text("5");
        configure(BASE_MAX, 1'b0, {VALUE_W{1'b1}});
        send_text("-5");
        send_text("zZ");
        configure(BASE_HEX, 1'b1, {VALUE_W{1'b1}});
        send_text("-0x8");
        configure(6'd2, 1'b1, 64'd0);
        send_text("0");
        send_text("1");
    endtask

    task automatic test_random_traffic(input int unsigned sender_gap,
                                       input int unsigned receiver_gap,
                                       input int unsigned n_chars);
        int unsigned        sent;
        int unsigned        chunk;
        int unsigned        burst;
        int unsigned        pick;
        logic [BASE_W-1:0]  base;
        logic [VALUE_W-1:0] limit;
        send_gap_pct = sender_gap;
        recv_gap_pct = receiver_gap;
        sent = 0;
        while (sent < n_chars)
        begin
            pick = $urandom_range(9);
            case (pick)
                0: base = BASE_AUTO;
                1: base = BASE_HEX;
                2: base = BASE_OCT;
                3: base = BASE_DEC;
                4: base = 6'd2;
                5: base = BASE_MAX;
                6: base = BASE_BAD;
                7: base = BASE_W'($urandom_range(BASE_MAX + 1, {BASE_W{1'b1}}));
                default: base = BASE_W'($urandom_range(2, BASE_MAX));
            endcase
            pick = $urandom_range(5);
            case (pick)
                0: limit = RESET_MAX_VALUE;
                1: limit = {VALUE_W{1'b1}};
                2: limit = {$urandom, $urandom};
                3: limit = VALUE_W'($urandom_range(1, 1000));
                4: limit = 64'hFFFF_FFFF;
                default: limit = 64'd1;
            endcase
            configure(base, $urandom_range(1) != 0, limit);
            chunk = 0;
            while (chunk < 40)
            begin
                send_random_string(burst);
                chunk += burst;
            end
            sent += chunk;
        end
    endtask

    task automatic test_long_string();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        configure(BASE_DEC, 1'b1, RESET_MAX_VALUE);
        repeat (40) send_char(CH_SPACE, 1'b0);
        send_text("73");
        send_text("5");
    endtask

    initial
    begin
        base_reg   = RESET_BASE;
        signed_reg = 1'b1;
        max_reg    = RESET_MAX_VALUE;
        clear_scan();
        send_gap_pct = 12;
        recv_gap_pct = 66;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_auto_base();
        test_base_extremes();
        test_random_traffic(12, 66, 140);
        test_random_traffic(66, 12, 140);
        test_random_traffic(0, 0, 140);
        test_long_string();
        wait_for_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
